// File: design/tpi_pkg.sv
// Package: types and constants for the triangle/plane slicer.
`default_nettype none
package tpi_pkg;
	localparam int CoordWidth = 32;
	localparam int FracBits = 16;
	localparam int CW = CoordWidth;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_CROSS = 2'd1;
	localparam logic [1:0] KIND_TOUCH = 2'd2;
	localparam logic [1:0] KIND_EDGE  = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_z;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_z;
		logic signed [CW-1:0] c_x;
		logic signed [CW-1:0] c_y;
		logic signed [CW-1:0] c_z;
		logic signed [CW-1:0] plane_z;
	} tri_t;

	typedef struct packed {
		logic signed [CW-1:0] p0_x;
		logic signed [CW-1:0] p0_y;
		logic signed [CW-1:0] p0_z;
		logic signed [CW-1:0] p1_x;
		logic signed [CW-1:0] p1_y;
		logic signed [CW-1:0] p1_z;
		logic [1:0]           kind;
	} seg_t;
endpackage
`default_nettype wire

// File: design/tpi_div_cell.sv
// Divider cell: one restoring quotient bit per cell, pipelined with its operands.
`default_nettype none
module tpi_div_cell import tpi_pkg::*; #(
	parameter int COORD_WIDTH = CoordWidth,
	parameter int FRAC_BITS = FracBits,
	parameter int NB = 2,
	parameter int PW = 8
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [COORD_WIDTH:0]  rem_in [NB],
	input  wire logic [COORD_WIDTH:0]  den_in [NB],
	input  wire logic [FRAC_BITS:0]    quo_in [NB],
	input  wire logic [PW-1:0]         pay_in,
	output logic      [COORD_WIDTH:0]  rem_out [NB],
	output logic      [COORD_WIDTH:0]  den_out [NB],
	output logic      [FRAC_BITS:0]    quo_out [NB],
	output logic      [PW-1:0]         pay_out
);
	logic [COORD_WIDTH+1:0] sh [NB];
	logic [COORD_WIDTH+1:0] df [NB];

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			sh[i] = {rem_in[i], 1'b0};
			df[i] = sh[i] - {1'b0, den_in[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NB; i++) begin
				rem_out[i] <= df[i][COORD_WIDTH+1] ? sh[i][COORD_WIDTH:0] : df[i][COORD_WIDTH:0];
				quo_out[i] <= {quo_in[i][FRAC_BITS-1:0], ~df[i][COORD_WIDTH+1]};
				den_out[i] <= den_in[i];
			end
			pay_out <= pay_in;
		end
	end
endmodule
`default_nettype wire

// File: design/triangle_plane_intersection.sv
// Top level: triangle/horizontal plane slicer, divider cell chain and lerp stages.
//
//  channel | signals                   | direction
//  in      | in_valid in_ready in_data | triangle + plane into block
//  out     | out_valid out_ready out_data | segment out of block
//
// One triangle per cycle while the output is not stalled; a triangle passes through
// classify, the seed cell, the divider cells (one quotient bit per cell), multiply and add/select stages.
// Reset clears the valid bits of every stage. The whole pipeline advances when the
// output register is empty or taken; a stalled output holds all stages.
`default_nettype none
module triangle_plane_intersection import tpi_pkg::*; #(
	parameter int FRAC_BITS = FracBits
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire tri_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output seg_t      out_data
);
	localparam int W = CoordWidth;
	localparam int NC = FRAC_BITS + 1;
	// payload: u0,d0,u1,d1 vertices (x,y), plane, kind, touch points
	localparam int PW = 8 * W + W + 2 + 6 * W;
	localparam int LAT = NC + 2;

	logic adv;
	logic [LAT-1:0] vld_q;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
			out_valid <= vld_q[LAT-1];
		end
	end

	// classify
	logic signed [W-1:0] vx [3], vy [3], vz [3];
	logic signed [W-1:0] pz;
	logic [2:0] upm, onm;
	logic [1:0] nu, non;
	logic [1:0] iu0, id0, iu1, id1;
	logic [1:0] io0, io1;
	logic [1:0] kind_c;

	always_comb begin
		vx[0] = in_data.a_x[W-1:0]; vy[0] = in_data.a_y[W-1:0]; vz[0] = in_data.a_z[W-1:0];
		vx[1] = in_data.b_x[W-1:0]; vy[1] = in_data.b_y[W-1:0]; vz[1] = in_data.b_z[W-1:0];
		vx[2] = in_data.c_x[W-1:0]; vy[2] = in_data.c_y[W-1:0]; vz[2] = in_data.c_z[W-1:0];
		pz = in_data.plane_z[W-1:0];
		for (int i = 0; i < 3; i++) begin
			upm[i] = vz[i] > pz;
			onm[i] = vz[i] == pz;
		end
		nu = 2'(upm[0]) + 2'(upm[1]) + 2'(upm[2]);
		non = 2'(onm[0]) + 2'(onm[1]) + 2'(onm[2]);
		iu0 = upm[0] ? 2'd0 : (upm[1] ? 2'd1 : 2'd2);
		iu1 = upm[2] ? 2'd2 : (upm[1] ? 2'd1 : 2'd0);
		id0 = !upm[0] ? 2'd0 : (!upm[1] ? 2'd1 : 2'd2);
		id1 = !upm[2] ? 2'd2 : (!upm[1] ? 2'd1 : 2'd0);
		io0 = onm[0] ? 2'd0 : (onm[1] ? 2'd1 : 2'd2);
		io1 = onm[2] ? 2'd2 : (onm[1] ? 2'd1 : 2'd0);
		if (nu == 2'd1) begin
			iu1 = iu0;
		end else begin
			id1 = id0;
		end
		if (non == 2'd1) io1 = io0;
		kind_c = KIND_NONE;
		if (nu == 2'd1 || nu == 2'd2) kind_c = KIND_CROSS;
		else if (nu == 2'd0 && non == 2'd1) kind_c = KIND_TOUCH;
		else if (nu == 2'd0 && non == 2'd2) kind_c = KIND_EDGE;
	end

	// stage 1 registers
	logic [PW-1:0] pay_s1;
	logic [W:0] num_s1 [2], den_s1 [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1[0] <= {vz[iu0][W-1], vz[iu0]} - {pz[W-1], pz};
			den_s1[0] <= {vz[iu0][W-1], vz[iu0]} - {vz[id0][W-1], vz[id0]};
			num_s1[1] <= {vz[iu1][W-1], vz[iu1]} - {pz[W-1], pz};
			den_s1[1] <= {vz[iu1][W-1], vz[iu1]} - {vz[id1][W-1], vz[id1]};
			pay_s1 <= {vx[iu0], vy[iu0], vx[id0], vy[id0],
				vx[iu1], vy[iu1], vx[id1], vy[id1], pz, kind_c,
				vx[io0], vy[io0], vz[io0], vx[io1], vy[io1], vz[io1]};
		end
	end

	// divider chain: seed cell takes integer part (num >= den -> quotient bit 0 is t>=1)
	logic [W:0] seed_rem [2];
	logic [FRAC_BITS:0] seed_quo [2];
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			seed_quo[i] = {{FRAC_BITS{1'b0}}, num_s1[i] >= den_s1[i]};
			seed_rem[i] = (num_s1[i] >= den_s1[i]) ? num_s1[i] - den_s1[i] : num_s1[i];
		end
	end

	logic [W:0] rem_s2 [2], den_s2 [2];
	logic [FRAC_BITS:0] quo_s2 [2];
	logic [PW-1:0] pay_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2 <= seed_rem;
			den_s2 <= den_s1;
			quo_s2 <= seed_quo;
			pay_s2 <= pay_s1;
		end
	end

	logic [W:0] rem_k [NC][2], den_k [NC][2];
	logic [FRAC_BITS:0] quo_k [NC][2];
	logic [PW-1:0] pay_k [NC];

	assign rem_k[0] = rem_s2;
	assign den_k[0] = den_s2;
	assign quo_k[0] = quo_s2;
	assign pay_k[0] = pay_s2;

	for (genvar g = 0; g < NC - 1; g++) begin : g_cell
		tpi_div_cell #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .NB(2), .PW(PW)) u_cell (
			.clk(clk), .en(adv),
			.rem_in(rem_k[g]), .den_in(den_k[g]), .quo_in(quo_k[g]), .pay_in(pay_k[g]),
			.rem_out(rem_k[g+1]), .den_out(den_k[g+1]), .quo_out(quo_k[g+1]),
			.pay_out(pay_k[g+1])
		);
	end

	// multiply stage
	logic [PW-1:0] pf;
	logic signed [W-1:0] ux0, uy0, dx0, dy0, ux1, uy1, dx1, dy1;
	assign pf = pay_k[NC-1];
	assign {ux0, uy0, dx0, dy0, ux1, uy1, dx1, dy1} = pf[PW-1 -: 8*W];

	localparam int MW = W + 1 + FRAC_BITS + 2;
	logic signed [MW-1:0] mx0_s3, my0_s3, mx1_s3, my1_s3;
	logic [PW-1:0] pay_s3;

	function automatic logic signed [MW-1:0] mulf(logic [FRAC_BITS:0] t,
			logic signed [W-1:0] u, logic signed [W-1:0] d);
		logic signed [W:0] df;
		logic signed [FRAC_BITS+1:0] ts;
		begin
			df = {d[W-1], d} - {u[W-1], u};
			ts = {1'b0, t};
			mulf = MW'(df * ts);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			mx0_s3 <= mulf(quo_k[NC-1][0], ux0, dx0);
			my0_s3 <= mulf(quo_k[NC-1][0], uy0, dy0);
			mx1_s3 <= mulf(quo_k[NC-1][1], ux1, dx1);
			my1_s3 <= mulf(quo_k[NC-1][1], uy1, dy1);
			pay_s3 <= pf;
		end
	end

	// add and select
	logic signed [W-1:0] qx0, qy0, qx1, qy1, qpz;
	logic [1:0] qk;
	logic signed [W-1:0] tx0, ty0, tz0, tx1, ty1, tz1;
	assign {qx0, qy0, qx1, qy1} = {pay_s3[PW-1 -: 2*W], pay_s3[PW-1-4*W -: 2*W]};
	assign {qpz, qk, tx0, ty0, tz0, tx1, ty1, tz1} = pay_s3[PW-1-8*W:0];

	seg_t res;
	always_comb begin
		res = '0;
		res.kind = qk;
		case (qk)
			KIND_CROSS: begin
				res.p0_x = qx0 + W'(mx0_s3 >>> FRAC_BITS);
				res.p0_y = qy0 + W'(my0_s3 >>> FRAC_BITS);
				res.p0_z = qpz;
				res.p1_x = qx1 + W'(mx1_s3 >>> FRAC_BITS);
				res.p1_y = qy1 + W'(my1_s3 >>> FRAC_BITS);
				res.p1_z = qpz;
			end
			KIND_TOUCH, KIND_EDGE: begin
				res.p0_x = tx0; res.p0_y = ty0; res.p0_z = tz0;
				res.p1_x = tx1; res.p1_y = ty1; res.p1_z = tz1;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) out_data <= res;
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");
	a_zero_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_NONE |-> out_data.p0_x == '0 && out_data.p1_z == '0)
		else $error("kind none with nonzero point");
	a_touch_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_TOUCH |-> out_data.p0_z == out_data.p1_z)
		else $error("touch endpoints differ");
endmodule
`default_nettype wire
